// ----- design/dpu_pkg.sv -----
// ----------------------------------------------------------------------------
// dpu_pkg
// Shared types and constants of the dirty page display updater.
// ----------------------------------------------------------------------------
package dpu_pkg;

	typedef enum logic [1:0] {
		KIND_CMD  = 2'd0,
		KIND_CTRL = 2'd1,
		KIND_DATA = 2'd2
	} dpu_kind_t;

	localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
	localparam logic [7:0] CMD_COL_HI    = 8'h10;
	localparam logic [7:0] CMD_PAD       = 8'h00;
	localparam logic [7:0] CTRL_DATA     = 8'h40;
	localparam logic [3:0] CMD_LEN       = 4'd4;
	localparam logic [3:0] CTRL_LEN      = 4'd1;
	localparam logic [3:0] CHUNK_LEN     = 4'd8;

	typedef struct packed {
		logic clear;
		logic take;
		logic update;
		logic out_cmd;
		logic out_ctrl;
		logic rd_first;
		logic out_data;
	} dpu_cmd_t;

	typedef struct packed {
		logic clear_done;
		logic page_ready;
		logic slot_free;
		logic last_word;
	} dpu_stat_t;

endpackage

// ----- design/dirty_page_display_updater.sv -----
// ----------------------------------------------------------------------------
// dirty_page_display_updater
// Shadow-compares frame-buffer bytes and emits update runs for changed pages.
// ----------------------------------------------------------------------------
// Each input byte is read from the shadow RAM, then compared and written back.
// A changed page adds a run of 2 + ceil(PAGE_WIDTH/8) output transactions,
// one per cycle when the sink is ready; input is held off during the run.
// The command transaction follows the compare of the page's last byte.
// After arst_n the shadow RAM is cleared, one entry a cycle, through all
// MAX_PAGES*PAGE_WIDTH entries (1024 by default) before the first byte.
module dirty_page_display_updater #(
	parameter int PAGE_WIDTH = 128,
	parameter int MAX_PAGES  = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,      // panel_tall
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] fb_byte
	input  logic        s_axis_tuser,   // [0] frame_start
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,   // [2:0] page_index, [66:3] payload, [70:67] byte_count
	output logic [2:0]  m_axis_tuser,   // [1:0] chunk_kind, [2] write_begins
	output logic        m_axis_tlast
);

	dpu_pkg::dpu_cmd_t  cmd;
	dpu_pkg::dpu_stat_t stat;
	logic [1:0]  chunk_kind;
	logic [2:0]  page_index;
	logic [63:0] payload;
	logic [3:0]  byte_count;
	logic        write_begins;

	dpu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	dpu_datapath #(
		.PAGE_WIDTH (PAGE_WIDTH),
		.MAX_PAGES  (MAX_PAGES)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.fb_byte      (s_axis_tdata),
		.frame_start  (s_axis_tuser),
		.out_ready    (m_axis_tready),
		.out_valid    (m_axis_tvalid),
		.chunk_kind   (chunk_kind),
		.page_index   (page_index),
		.payload      (payload),
		.byte_count   (byte_count),
		.write_begins (write_begins),
		.last         (m_axis_tlast)
	);

	assign m_axis_tdata = {1'b0, byte_count, payload, page_index};
	assign m_axis_tuser = {write_begins, chunk_kind};

	// an accepted byte always needs its compare cycle before the next one
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("byte accepted during compare cycle");

	// a pending command chunk means a run is in progress and input is held off
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[1:0] == dpu_pkg::KIND_CMD) |-> !s_axis_tready)
		else $error("input accepted while update run in progress");

	// only a data chunk can close a run
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tlast) |-> (m_axis_tuser[1:0] == dpu_pkg::KIND_DATA))
		else $error("run closed by non-data chunk");

	// no input is taken while the shadow is still being cleared
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |-> !s_axis_tready)
		else $error("input ready during shadow clear");

endmodule

// ----- design/dpu_ram.sv -----
// ----------------------------------------------------------------------------
// dpu_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module dpu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- design/dpu_ctrl.sv -----
// ----------------------------------------------------------------------------
// dpu_ctrl
// Sequencer: shadow clear, byte lookup/update, page update run emission.
// ----------------------------------------------------------------------------
module dpu_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  dpu_pkg::dpu_stat_t  stat,
	output dpu_pkg::dpu_cmd_t   cmd
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CMP,
		ST_CMD,
		ST_CTRL,
		ST_DATA
	} state_t;

	state_t state_q;
	logic   ready_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_CLEAR: cmd.clear = 1'b1;
			ST_IDLE:  cmd.take = in_valid;
			ST_CMP:   cmd.update = 1'b1;
			ST_CMD:   cmd.out_cmd = stat.slot_free;
			ST_CTRL: begin
				cmd.rd_first = 1'b1;
				cmd.out_ctrl = stat.slot_free;
			end
			ST_DATA:  cmd.out_data = stat.slot_free;
			default:  cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			ready_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					if (stat.clear_done) begin
						state_q <= ST_IDLE;
						ready_q <= 1'b1;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_CMP;
						ready_q <= 1'b0;
					end
				end
				ST_CMP: begin
					if (stat.page_ready) begin
						state_q <= ST_CMD;
					end else begin
						state_q <= ST_IDLE;
						ready_q <= 1'b1;
					end
				end
				ST_CMD: begin
					if (stat.slot_free) begin
						state_q <= ST_CTRL;
					end
				end
				ST_CTRL: begin
					if (stat.slot_free) begin
						state_q <= ST_DATA;
					end
				end
				ST_DATA: begin
					if (stat.slot_free && stat.last_word) begin
						state_q <= ST_IDLE;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					ready_q <= 1'b1;
				end
			endcase
		end
	end

	assign in_ready = ready_q;

endmodule

// ----- design/dpu_datapath.sv -----
// ----------------------------------------------------------------------------
// dpu_datapath
// Position counters, shadow frame and page buffer memories, output register.
// ----------------------------------------------------------------------------
module dpu_datapath #(
	parameter int PAGE_WIDTH = 128,
	parameter int MAX_PAGES  = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dpu_pkg::dpu_cmd_t  cmd,
	output dpu_pkg::dpu_stat_t stat,
	input  logic               cfg_we,
	input  logic               cfg_wdata,
	input  logic [7:0]         fb_byte,
	input  logic               frame_start,
	input  logic               out_ready,
	output logic               out_valid,
	output logic [1:0]         chunk_kind,
	output logic [2:0]         page_index,
	output logic [63:0]        payload,
	output logic [3:0]         byte_count,
	output logic               write_begins,
	output logic               last
);

	localparam int SH_DEPTH = MAX_PAGES * PAGE_WIDTH;
	localparam int SH_AW    = $clog2(SH_DEPTH);
	localparam int CW       = $clog2(PAGE_WIDTH);
	localparam int WORDS    = (PAGE_WIDTH + 7) / 8;
	localparam int WA       = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam logic [CW-1:0]    LAST_COL   = CW'(PAGE_WIDTH - 1);
	localparam logic [WA-1:0]    LAST_WORD  = WA'(WORDS - 1);
	localparam logic [3:0]       LAST_LEN   = 4'(PAGE_WIDTH - 8 * (WORDS - 1));
	localparam logic [3:0]       PAGES_TALL = 4'((MAX_PAGES < 8) ? MAX_PAGES : 8);
	localparam logic [3:0]       PAGES_SHRT = 4'((MAX_PAGES < 4) ? MAX_PAGES : 4);
	localparam logic [SH_AW-1:0] CLR_LAST   = SH_AW'(SH_DEPTH - 1);

	logic             panel_tall_q;
	logic [3:0]       pages;
	logic [CW-1:0]    col_q, col_s1, eff_col;
	logic [2:0]       page_q, page_s1, eff_page;
	logic [SH_AW-1:0] addr_q, addr_s1, eff_addr;
	logic [7:0]       byte_s1;
	logic             dirty_q, dirty_next;
	logic [SH_AW-1:0] clr_q;
	logic [63:0]      asm_q, asm_next;
	logic             word_end;
	logic [WA-1:0]    wd_q;
	logic [3:0]       page_inc;

	logic             sh_we;
	logic [SH_AW-1:0] sh_waddr;
	logic [7:0]       sh_wdata, sh_rdata;
	logic             pg_re;
	logic [WA-1:0]    pg_raddr;
	logic [63:0]      pg_rdata;

	logic             out_valid_q;
	dpu_pkg::dpu_kind_t kind_q;
	logic [2:0]       pidx_q;
	logic [63:0]      payload_q;
	logic [3:0]       count_q;
	logic             begins_q, last_q;

	assign pages = panel_tall_q ? PAGES_TALL : PAGES_SHRT;

	always_comb begin
		if (frame_start || ({1'b0, page_q} >= pages)) begin
			eff_col  = '0;
			eff_page = '0;
			eff_addr = '0;
		end else begin
			eff_col  = col_q;
			eff_page = page_q;
			eff_addr = addr_q;
		end
	end

	assign dirty_next = ((col_s1 == '0) ? 1'b0 : dirty_q) | (sh_rdata != byte_s1);
	assign page_inc   = {1'b0, page_s1} + 4'd1;
	assign word_end   = (col_s1[2:0] == 3'd7) || (col_s1 == LAST_COL);
	assign asm_next   = ((col_s1[2:0] == 3'd0) ? 64'd0 : asm_q)
		| (64'(byte_s1) << {col_s1[2:0], 3'b000});

	assign sh_we    = cmd.clear | cmd.update;
	assign sh_waddr = cmd.clear ? clr_q : addr_s1;
	assign sh_wdata = cmd.clear ? 8'd0 : byte_s1;

	dpu_ram #(.WIDTH(8), .DEPTH(SH_DEPTH)) u_shadow (
		.clk     (clk),
		.wr_en   (sh_we),
		.wr_addr (sh_waddr),
		.wr_data (sh_wdata),
		.rd_en   (cmd.take),
		.rd_addr (eff_addr),
		.rd_data (sh_rdata)
	);

	assign pg_re    = cmd.rd_first | (cmd.out_data & (wd_q != LAST_WORD));
	assign pg_raddr = cmd.rd_first ? '0 : wd_q + WA'(1);

	dpu_ram #(.WIDTH(64), .DEPTH(WORDS)) u_page (
		.clk     (clk),
		.wr_en   (cmd.update & word_end),
		.wr_addr (WA'(col_s1 >> 3)),
		.wr_data (asm_next),
		.rd_en   (pg_re),
		.rd_addr (pg_raddr),
		.rd_data (pg_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			col_s1  <= eff_col;
			page_s1 <= eff_page;
			addr_s1 <= eff_addr;
			byte_s1 <= fb_byte;
		end
		if (cmd.update) begin
			asm_q <= asm_next;
		end
		if (cmd.out_cmd) begin
			payload_q <= {32'd0, dpu_pkg::CMD_COL_HI, dpu_pkg::CMD_PAD,
				dpu_pkg::CMD_PAGE_BASE | {5'd0, page_s1}, dpu_pkg::CMD_PAD};
			count_q   <= dpu_pkg::CMD_LEN;
			begins_q  <= 1'b1;
			last_q    <= 1'b0;
			kind_q    <= dpu_pkg::KIND_CMD;
			pidx_q    <= page_s1;
		end else if (cmd.out_ctrl) begin
			payload_q <= {56'd0, dpu_pkg::CTRL_DATA};
			count_q   <= dpu_pkg::CTRL_LEN;
			begins_q  <= 1'b1;
			last_q    <= 1'b0;
			kind_q    <= dpu_pkg::KIND_CTRL;
		end else if (cmd.out_data) begin
			payload_q <= pg_rdata;
			count_q   <= (wd_q == LAST_WORD) ? LAST_LEN : dpu_pkg::CHUNK_LEN;
			begins_q  <= 1'b0;
			last_q    <= (wd_q == LAST_WORD);
			kind_q    <= dpu_pkg::KIND_DATA;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			panel_tall_q <= 1'b1;
			col_q        <= '0;
			page_q       <= '0;
			addr_q       <= '0;
			dirty_q      <= 1'b0;
			clr_q        <= '0;
			wd_q         <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				panel_tall_q <= cfg_wdata;
			end
			if (cmd.clear) begin
				clr_q <= clr_q + SH_AW'(1);
			end
			if (cmd.update) begin
				dirty_q <= stat.page_ready ? 1'b0 : dirty_next;
				if (col_s1 == LAST_COL) begin
					col_q <= '0;
					if (page_inc >= pages) begin
						page_q <= '0;
						addr_q <= '0;
					end else begin
						page_q <= page_inc[2:0];
						addr_q <= addr_s1 + SH_AW'(1);
					end
				end else begin
					col_q  <= col_s1 + CW'(1);
					page_q <= page_s1;
					addr_q <= addr_s1 + SH_AW'(1);
				end
			end
			if (cmd.out_ctrl) begin
				wd_q <= '0;
			end else if (cmd.out_data) begin
				wd_q <= wd_q + WA'(1);
			end
			if (cmd.out_cmd || cmd.out_ctrl || cmd.out_data) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.clear_done = (clr_q == CLR_LAST);
	assign stat.page_ready = (col_s1 == LAST_COL) && dirty_next;
	assign stat.slot_free  = !out_valid_q || out_ready;
	assign stat.last_word  = (wd_q == LAST_WORD);

	assign out_valid    = out_valid_q;
	assign chunk_kind   = kind_q;
	assign page_index   = pidx_q;
	assign payload      = payload_q;
	assign byte_count   = count_q;
	assign write_begins = begins_q;
	assign last         = last_q;

endmodule

// ----- bench/dirty_page_display_updater_tb.sv -----
// ----------------------------------------------------------------------------
// dirty_page_display_updater_tb
// Streams frame-buffer pages through the updater and checks every output
// transaction, field by field, against a shadow-frame model kept in the bench.
// A table of rows, most a page long, covers both panel heights, clean and
// changed pages, the wrap at the end of a frame, a height change mid-frame and
// a frame restart inside a page. Random phases follow: mostly fills up to a page
// end that copy or alter the shadow, plus restarts and short noise bursts.
// ----------------------------------------------------------------------------
module dirty_page_display_updater_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PAGE_W      = 128;
	localparam int PAGES_MAX   = 8;
	localparam int TALL_PAGES  = 8;
	localparam int SHORT_PAGES = 4;
	localparam int CHUNKS      = PAGE_W / 8;
	localparam int N_ROWS      = 19;

	typedef struct {
		dpu_pkg::dpu_kind_t kind;
		logic [2:0]  page;
		logic [63:0] payload;
		logic [3:0]  count;
		logic        begins;
		logic        is_last;
	} chunk_t;

	typedef enum {PAT_CONST, PAT_RAMP, PAT_RAND, PAT_HEAD, PAT_TAIL} fill_t;
	typedef enum {MIX_KEEP, MIX_SPARSE, MIX_NOISY} page_mix_t;

	typedef struct {
		int         tall;     // -1: panel height left alone
		logic       restart;
		int         nbytes;
		fill_t      fill;
		logic [7:0] val;
		int         runs;     // -1: not checked
	} plan_row_t;

	plan_row_t plan [N_ROWS] = '{
		'{ 1, 1'b1, 128, PAT_CONST, 8'h00, 0},
		'{-1, 1'b0, 128, PAT_CONST, 8'hFF, 1},
		'{-1, 1'b0, 128, PAT_RAMP,  8'h00, 1},
		'{-1, 1'b0, 128, PAT_CONST, 8'h00, 0},
		'{-1, 1'b0, 128, PAT_TAIL,  8'h80, 1},
		'{-1, 1'b0, 128, PAT_HEAD,  8'h01, 1},
		'{-1, 1'b0,  64, PAT_RAND,  8'h00, 0},
		'{ 0, 1'b0, 128, PAT_CONST, 8'h00, 0},  // past last page: wraps to page 0
		'{-1, 1'b0, 128, PAT_CONST, 8'hFF, 0},
		'{-1, 1'b0, 128, PAT_CONST, 8'hAA, 1},
		'{-1, 1'b0, 128, PAT_RAND,  8'h00, -1},
		'{-1, 1'b0, 128, PAT_CONST, 8'h55, 1},  // next frame without restart
		'{-1, 1'b0,  50, PAT_CONST, 8'h00, 0},
		'{-1, 1'b1, 128, PAT_CONST, 8'h55, 0},  // restart abandons page 1
		'{ 1, 1'b0, 128, PAT_CONST, 8'hFF, 1},
		'{-1, 1'b0, 128, PAT_RAMP,  8'h80, 1},
		'{-1, 1'b1, 128, PAT_CONST, 8'h55, 0},
		'{-1, 1'b0, 640, PAT_RAND,  8'h00, -1},
		'{-1, 1'b0, 256, PAT_CONST, 8'hFF, 2}
	};

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        cfg_we        = 1'b0;
	logic        cfg_wdata     = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata  = 8'h00;  // [7:0] fb_byte
	logic        s_axis_tuser  = 1'b0;   // [0] frame_start
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [71:0] m_axis_tdata;           // [2:0] page_index, [66:3] payload, [70:67] byte_count
	logic [2:0]  m_axis_tuser;           // [1:0] chunk_kind, [2] write_begins
	logic        m_axis_tlast;

	logic [7:0]  shadow_mem [PAGES_MAX*PAGE_W];
	logic [7:0]  page_mem [PAGE_W];
	int unsigned next_pos     = 0;
	logic        page_changed = 1'b0;
	logic        panel_tall_q = 1'b1;
	chunk_t      chunks_due[$];

	int errors     = 0;
	int runs_seen  = 0;
	int burst_left = 0;
	int rx_mode    = 0;
	int rx_left    = 0;
	int rx_tick    = 0;

	dirty_page_display_updater #(
		.PAGE_WIDTH(PAGE_W),
		.MAX_PAGES (PAGES_MAX)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic int unsigned frame_bytes();
		return (panel_tall_q ? TALL_PAGES : SHORT_PAGES) * PAGE_W;
	endfunction

	// position the next byte lands on
	function automatic int unsigned landing(input logic restart);
		int unsigned p;
		p = restart ? 0 : next_pos;
		if (p >= frame_bytes())
			p = 0;
		return p;
	endfunction

	function automatic void take_byte(input logic [7:0] b, input logic restart);
		int unsigned p;
		int unsigned col;
		logic [2:0]  pg;
		chunk_t      c;
		int          k;
		int          j;
		p   = landing(restart);
		col = p % PAGE_W;
		pg  = 3'(p / PAGE_W);
		if (col == 0)
			page_changed = 1'b0;
		if (shadow_mem[p] != b)
			page_changed = 1'b1;
		shadow_mem[p] = b;
		page_mem[col] = b;
		if (col == PAGE_W - 1 && page_changed) begin
			c.kind    = dpu_pkg::KIND_CMD;
			c.page    = pg;
			c.payload = {32'd0, dpu_pkg::CMD_COL_HI, dpu_pkg::CMD_PAD,
				dpu_pkg::CMD_PAGE_BASE | {5'd0, pg}, dpu_pkg::CMD_PAD};
			c.count   = dpu_pkg::CMD_LEN;
			c.begins  = 1'b1;
			c.is_last = 1'b0;
			chunks_due.push_back(c);
			c.kind    = dpu_pkg::KIND_CTRL;
			c.payload = {56'd0, dpu_pkg::CTRL_DATA};
			c.count   = dpu_pkg::CTRL_LEN;
			chunks_due.push_back(c);
			for (k = 0; k < CHUNKS; k++) begin
				c.kind   = dpu_pkg::KIND_DATA;
				c.count  = dpu_pkg::CHUNK_LEN;
				c.begins = 1'b0;
				for (j = 0; j < 8; j++)
					c.payload[8*j +: 8] = page_mem[8*k + j];
				c.is_last = (k == CHUNKS - 1);
				chunks_due.push_back(c);
			end
			page_changed = 1'b0;
		end
		next_pos = p + 1;
		if (next_pos >= frame_bytes())
			next_pos = 0;
	endfunction

	function automatic void check_field(input string field, input logic [63:0] exp_v,
			input logic [63:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s: expected %0h, actual %0h", field, exp_v, act_v);
			errors++;
		end
	endfunction

	// called at a falling edge, returns at a falling edge
	task automatic send_byte(input logic [7:0] b, input logic restart);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
				: $urandom_range(1, 24);
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tuser  <= restart;
		do @(posedge clk); while (!s_axis_tready);
		take_byte(b, restart);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (chunks_due.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic set_panel(input logic tall);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= tall;
		@(negedge clk);
		cfg_we <= 1'b0;
		panel_tall_q = tall;
	endtask

	// bytes up to the end of the current page, copied from the shadow or altered
	task automatic fill_page(input page_mix_t mix, input logic restart);
		int unsigned p;
		logic [7:0]  b;
		logic        first;
		first = restart;
		do begin
			p = landing(first);
			b = shadow_mem[p];
			if (mix == MIX_NOISY || (mix == MIX_SPARSE && $urandom_range(0, 15) == 0))
				b = 8'($urandom);
			send_byte(b, first);
			first = 1'b0;
		end while (p % PAGE_W != PAGE_W - 1);
	endtask

	function automatic logic [7:0] row_byte(input plan_row_t row, input int i);
		case (row.fill)
			PAT_CONST: return row.val;
			PAT_RAMP:  return row.val + 8'(i);
			PAT_RAND:  return 8'($urandom);
			PAT_HEAD:  return (i == 0) ? row.val : 8'h00;
			default:   return (i == row.nbytes - 1) ? row.val : 8'h00;
		endcase
	endfunction

	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 2);
			rx_left = $urandom_range(16, 160);
		end else begin
			rx_left--;
		end
		rx_tick++;
		case (rx_mode)
			0:       m_axis_tready <= 1'b1;
			1:       m_axis_tready <= ($urandom_range(0, 2) != 0);
			default: m_axis_tready <= (rx_tick % 7) > 2;
		endcase
	end

	always @(posedge clk) begin
		chunk_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (m_axis_tlast)
				runs_seen++;
			if (chunks_due.size() == 0) begin
				$error("unexpected transaction: tdata %h tuser %h tlast %b",
					m_axis_tdata, m_axis_tuser, m_axis_tlast);
				errors++;
			end else begin
				want = chunks_due.pop_front();
				check_field("chunk_kind", want.kind, m_axis_tuser[1:0]);
				check_field("page_index", want.page, m_axis_tdata[2:0]);
				check_field("payload", want.payload, m_axis_tdata[66:3]);
				check_field("byte_count", want.count, m_axis_tdata[70:67]);
				check_field("write_begins", want.begins, m_axis_tuser[2]);
				check_field("last", want.is_last, m_axis_tlast);
			end
		end
	end

	initial begin
		int i;
		int n;
		int ph;
		int base;
		int rand_base;
		for (i = 0; i < PAGES_MAX*PAGE_W; i++)
			shadow_mem[i] = 8'h00;
		for (i = 0; i < PAGE_W; i++)
			page_mem[i] = 8'h00;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		set_panel(1'b1);

		foreach (plan[r]) begin
			if (plan[r].tall >= 0)
				set_panel(plan[r].tall != 0);
			base = runs_seen;
			for (i = 0; i < plan[r].nbytes; i++)
				send_byte(row_byte(plan[r], i), plan[r].restart && i == 0);
			wait_idle();
			if (plan[r].runs >= 0 && runs_seen - base != plan[r].runs) begin
				$error("update runs in row %0d: expected %0d, actual %0d",
					r, plan[r].runs, runs_seen - base);
				errors++;
			end
		end

		rand_base = runs_seen;
		for (ph = 0; ph < 30 && (ph < 4 || runs_seen - rand_base < 6); ph++) begin
			set_panel(ph == 0 ? 1'b0 : ph == 1 ? 1'b1 : 1'($urandom_range(0, 1)));
			repeat ($urandom_range(2, 4)) begin
				n = $urandom_range(0, 9);
				if (n < 6) begin
					fill_page(page_mix_t'($urandom_range(0, 2)), 1'b0);
				end else if (n < 8) begin
					fill_page(page_mix_t'($urandom_range(0, 2)), 1'b1);
				end else begin
					n = $urandom_range(1, 40);
					for (i = 0; i < n; i++)
						send_byte(8'($urandom), i == 0 && $urandom_range(0, 1) == 1);
				end
			end
		end

		wait_idle();
		repeat (20) @(negedge clk);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
